// ===== sv/contactor_precharge_sequencer_unit_defines.svh =====
// Assertion macros shared by the contactor precharge sequencer modules.
// Depends on nothing; the including module supplies clock and reset.
`ifndef CONTACTOR_PRECHARGE_SEQUENCER_UNIT_DEFINES_SVH
`define CONTACTOR_PRECHARGE_SEQUENCER_UNIT_DEFINES_SVH

// consequence holds in the same cycle as the condition
`define CPS_ASSERT_SAME(label, cond, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
   else $error(msg);

// consequence holds in the following cycle
`define CPS_ASSERT_NEXT(label, cond, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
   else $error(msg);

`endif

// ===== sv/cps_pkg.sv =====
// Package for the contactor precharge sequencer: types, codes and constants.
// Used by cps_csr, cps_seq and contactor_precharge_sequencer_unit.
package cps_pkg;

   localparam int unsigned FAULT_TICK_LIMIT_DEF  = 1000;
   localparam int unsigned NEG_SETTLE_MS_DEF     = 500;
   localparam int unsigned PRECHARGE_DONE_MS_DEF = 1000;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned DUTY_WIDTH      = 10;
   localparam int unsigned TICK_WIDTH      = 11;

   localparam logic [DUTY_WIDTH-1:0] FULL_DUTY = 10'h3FF;
   localparam logic [TICK_WIDTH-1:0] FAULT_SAT = 11'h7FF;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTROL_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERTED_LOGIC    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PWM_ECONOMIZE     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRECHARGE_TIME_MS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_DUTY         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BATTERY2_ENABLE   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STARTUP_DELAY_MS  = 3'd6;

   localparam logic [15:0]           PRECHARGE_TIME_RST = 16'd100;
   localparam logic [DUTY_WIDTH-1:0] HOLD_DUTY_RST      = 10'd250;
   localparam logic [15:0]           STARTUP_DELAY_RST  = 16'd10000;

   typedef enum logic [2:0] {
      PH_OPEN     = 3'd0,
      PH_START    = 3'd1,
      PH_NEGATIVE = 3'd2,
      PH_PRECHARGE = 3'd3,
      PH_POSITIVE = 3'd4,
      PH_DONE     = 3'd5,
      PH_SHUTDOWN = 3'd6
   } cps_phase_type;

   typedef enum logic [1:0] {
      ST_OPEN      = 2'd0,
      ST_ENGAGED   = 2'd1,
      ST_FAULT     = 2'd2,
      ST_PRECHARGE = 2'd3
   } cps_status_type;

   typedef struct packed {
      logic                  control_enable;
      logic                  inverted_logic;
      logic                  pwm_economize;
      logic [15:0]           precharge_time_ms;
      logic [DUTY_WIDTH-1:0] hold_duty;
      logic                  battery2_enable;
      logic [15:0]           startup_delay_ms;
   } cps_cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        bms_fault;
      logic        closing_allowed;
      logic        estop_active;
      logic        battery2_allowed;
   } cps_req_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0] negative_duty;
      logic [DUTY_WIDTH-1:0] positive_duty;
      logic                  precharge_level;
      logic [1:0]            engage_status;
      logic                  open_contactor_error;
      logic                  battery2_level;
      logic                  battery2_engaged;
      logic [2:0]            sequence_phase;
   } cps_rsp_type;

endpackage

// ===== sv/cps_csr.sv =====
// Configuration registers of the contactor precharge sequencer.
// Depends on cps_pkg for the register indexes, reset values and cps_cfg_type.
module cps_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cps_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output cps_pkg::cps_cfg_type                 cfg
);

   cps_pkg::cps_cfg_type cfg_ff;
   cps_pkg::cps_cfg_type cfg_in;
   logic                 write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_index)
            cps_pkg::CSR_CONTROL_ENABLE:    cfg_in.control_enable    = csr_data[0];
            cps_pkg::CSR_INVERTED_LOGIC:    cfg_in.inverted_logic    = csr_data[0];
            cps_pkg::CSR_PWM_ECONOMIZE:     cfg_in.pwm_economize     = csr_data[0];
            cps_pkg::CSR_PRECHARGE_TIME_MS: cfg_in.precharge_time_ms = csr_data;
            cps_pkg::CSR_HOLD_DUTY:
               cfg_in.hold_duty = csr_data[cps_pkg::DUTY_WIDTH-1:0];
            cps_pkg::CSR_BATTERY2_ENABLE:   cfg_in.battery2_enable   = csr_data[0];
            cps_pkg::CSR_STARTUP_DELAY_MS:  cfg_in.startup_delay_ms  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_enable    <= 1'b0;
         cfg_ff.inverted_logic    <= 1'b0;
         cfg_ff.pwm_economize     <= 1'b0;
         cfg_ff.precharge_time_ms <= cps_pkg::PRECHARGE_TIME_RST;
         cfg_ff.hold_duty         <= cps_pkg::HOLD_DUTY_RST;
         cfg_ff.battery2_enable   <= 1'b0;
         cfg_ff.startup_delay_ms  <= cps_pkg::STARTUP_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/cps_seq.sv =====
// Sequencer state and next-state logic for one control tick.
// Depends on cps_pkg and contactor_precharge_sequencer_unit_defines.svh.
`include "contactor_precharge_sequencer_unit_defines.svh"

module cps_seq #(
   parameter int unsigned FAULT_TICK_LIMIT  = cps_pkg::FAULT_TICK_LIMIT_DEF,
   parameter int unsigned NEG_SETTLE_MS     = cps_pkg::NEG_SETTLE_MS_DEF,
   parameter int unsigned PRECHARGE_DONE_MS = cps_pkg::PRECHARGE_DONE_MS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 proc_en,
   input  cps_pkg::cps_req_type req,
   input  cps_pkg::cps_cfg_type cfg,
   output cps_pkg::cps_rsp_type rsp
);

   localparam logic [cps_pkg::TICK_WIDTH-1:0] FAULT_LIMIT =
      cps_pkg::TICK_WIDTH'(FAULT_TICK_LIMIT);
   localparam logic [31:0] NEG_SETTLE  = 32'(NEG_SETTLE_MS);
   localparam logic [31:0] CHARGE_DONE = 32'(PRECHARGE_DONE_MS);

   cps_pkg::cps_phase_type              phase_ff, phase_in;
   cps_pkg::cps_status_type             status_ff, status_in;
   logic [cps_pkg::TICK_WIDTH-1:0]      ticks_ff, ticks_in;
   logic [31:0]                         start_ff, start_in;
   logic [cps_pkg::DUTY_WIDTH-1:0]      neg_ff, neg_in;
   logic [cps_pkg::DUTY_WIDTH-1:0]      pos_ff, pos_in;
   logic                                pre_ff, pre_in;
   logic                                sec_drive_ff, sec_drive_in;
   logic                                sec_engaged_ff, sec_engaged_in;

   logic [31:0]                         elapsed;
   logic                                b2_close;
   logic                                closing_req;
   logic                                started;
   logic [cps_pkg::DUTY_WIDTH-1:0]      open_duty;
   logic [cps_pkg::DUTY_WIDTH-1:0]      full_duty;
   logic [cps_pkg::DUTY_WIDTH-1:0]      hold_duty;
   logic [cps_pkg::DUTY_WIDTH-1:0]      level_duty;

   assign elapsed     = req.now_ms - start_ff;
   assign b2_close    = (phase_ff == cps_pkg::PH_DONE) && req.battery2_allowed;
   assign closing_req = req.closing_allowed && !req.estop_active;
   assign started     = req.now_ms >= {16'd0, cfg.startup_delay_ms};
   assign level_duty  = cfg.inverted_logic ? '0 : cps_pkg::FULL_DUTY;
   assign open_duty   = (cfg.pwm_economize || !cfg.inverted_logic) ? '0 : cps_pkg::FULL_DUTY;
   assign full_duty   = cfg.pwm_economize ? cps_pkg::FULL_DUTY : level_duty;
   assign hold_duty   = cfg.pwm_economize ? cfg.hold_duty : level_duty;

   always_comb begin
      phase_in       = phase_ff;
      status_in      = status_ff;
      ticks_in       = ticks_ff;
      start_in       = start_ff;
      neg_in         = neg_ff;
      pos_in         = pos_ff;
      pre_in         = pre_ff;
      sec_drive_in   = sec_drive_ff;
      sec_engaged_in = sec_engaged_ff;
      if (proc_en) begin
         if (cfg.battery2_enable) begin
            sec_drive_in   = b2_close ^ cfg.inverted_logic;
            sec_engaged_in = b2_close;
         end
         if (cfg.control_enable) begin
            if (!req.bms_fault) begin
               ticks_in = '0;
            end else if (ticks_ff != cps_pkg::FAULT_SAT) begin
               ticks_in = ticks_ff + 1'b1;
            end
            if (ticks_in > FAULT_LIMIT) begin
               phase_in = cps_pkg::PH_SHUTDOWN;
            end
            if (phase_in == cps_pkg::PH_SHUTDOWN) begin
               pre_in    = cfg.inverted_logic;
               neg_in    = open_duty;
               pos_in    = open_duty;
               status_in = cps_pkg::ST_FAULT;
            end else begin
               if (phase_in == cps_pkg::PH_OPEN) begin
                  pre_in    = cfg.inverted_logic;
                  neg_in    = open_duty;
                  pos_in    = open_duty;
                  status_in = cps_pkg::ST_OPEN;
                  if (closing_req) begin
                     phase_in = cps_pkg::PH_START;
                  end
               end
               if (phase_in == cps_pkg::PH_DONE) begin
                  if (!closing_req) begin
                     phase_in = cps_pkg::PH_OPEN;
                  end
               end else if (started) begin
                  unique case (phase_in)
                     cps_pkg::PH_START: begin
                        neg_in    = full_duty;
                        start_in  = req.now_ms;
                        phase_in  = cps_pkg::PH_NEGATIVE;
                        status_in = cps_pkg::ST_PRECHARGE;
                     end
                     cps_pkg::PH_NEGATIVE: begin
                        if (elapsed >= NEG_SETTLE) begin
                           pre_in    = !cfg.inverted_logic;
                           start_in  = req.now_ms;
                           phase_in  = cps_pkg::PH_PRECHARGE;
                           status_in = cps_pkg::ST_PRECHARGE;
                        end
                     end
                     cps_pkg::PH_PRECHARGE: begin
                        if (elapsed >= {16'd0, cfg.precharge_time_ms}) begin
                           pos_in    = full_duty;
                           start_in  = req.now_ms;
                           phase_in  = cps_pkg::PH_POSITIVE;
                           status_in = cps_pkg::ST_PRECHARGE;
                        end
                     end
                     cps_pkg::PH_POSITIVE: begin
                        if (elapsed >= CHARGE_DONE) begin
                           pre_in    = cfg.inverted_logic;
                           neg_in    = hold_duty;
                           pos_in    = hold_duty;
                           phase_in  = cps_pkg::PH_DONE;
                           status_in = cps_pkg::ST_ENGAGED;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= cps_pkg::PH_OPEN;
         status_ff      <= cps_pkg::ST_OPEN;
         ticks_ff       <= '0;
         start_ff       <= '0;
         neg_ff         <= '0;
         pos_ff         <= '0;
         pre_ff         <= 1'b0;
         sec_drive_ff   <= 1'b0;
         sec_engaged_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         status_ff      <= status_in;
         ticks_ff       <= ticks_in;
         start_ff       <= start_in;
         neg_ff         <= neg_in;
         pos_ff         <= pos_in;
         pre_ff         <= pre_in;
         sec_drive_ff   <= sec_drive_in;
         sec_engaged_ff <= sec_engaged_in;
      end
   end

   always_comb begin
      rsp.negative_duty        = neg_in;
      rsp.positive_duty        = pos_in;
      rsp.precharge_level      = pre_in;
      rsp.engage_status        = status_in;
      rsp.open_contactor_error = phase_in == cps_pkg::PH_SHUTDOWN;
      rsp.battery2_level       = sec_drive_in;
      rsp.battery2_engaged     = sec_engaged_in;
      rsp.sequence_phase       = phase_in;
   end

   `CPS_ASSERT_NEXT(a_shutdown_sticky, phase_ff == cps_pkg::PH_SHUTDOWN, phase_ff == cps_pkg::PH_SHUTDOWN, "shutdown released without reset")
   `CPS_ASSERT_SAME(a_shutdown_status, phase_ff == cps_pkg::PH_SHUTDOWN, status_ff == cps_pkg::ST_FAULT, "shutdown without fault status")
   `CPS_ASSERT_NEXT(a_disabled_hold, proc_en && !cfg.control_enable, $stable(phase_ff) && $stable(ticks_ff), "sequence moved while disabled")
   `CPS_ASSERT_NEXT(a_idle_hold, !proc_en, $stable(phase_ff) && $stable(sec_engaged_ff), "state moved with no item")

endmodule

// ===== sv/contactor_precharge_sequencer_unit.sv =====
// Contactor precharge sequencer: one control tick in, one result item out.
// Items pass from the input register to the result register, which drives result valid.
// Throughput: one item per cycle while rsp_stall is low; result reloads as it is taken.
// Reset (synchronous, active high) clears both valid flags and the sequencer state and
// loads the configuration defaults; the block accepts items once reset is low.
// Depends on cps_pkg, cps_csr, cps_seq and the shared assertion macros.
`include "contactor_precharge_sequencer_unit_defines.svh"

module contactor_precharge_sequencer_unit #(
   parameter int unsigned FAULT_TICK_LIMIT  = cps_pkg::FAULT_TICK_LIMIT_DEF,
   parameter int unsigned NEG_SETTLE_MS     = cps_pkg::NEG_SETTLE_MS_DEF,
   parameter int unsigned PRECHARGE_DONE_MS = cps_pkg::PRECHARGE_DONE_MS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [31:0]                         req_now_ms,
   input  logic                                req_bms_fault,
   input  logic                                req_closing_allowed,
   input  logic                                req_estop_active,
   input  logic                                req_battery2_allowed,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cps_pkg::DUTY_WIDTH-1:0]      rsp_negative_duty,
   output logic [cps_pkg::DUTY_WIDTH-1:0]      rsp_positive_duty,
   output logic                                rsp_precharge_level,
   output logic [1:0]                          rsp_engage_status,
   output logic                                rsp_open_contactor_error,
   output logic                                rsp_battery2_level,
   output logic                                rsp_battery2_engaged,
   output logic [2:0]                          rsp_sequence_phase,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cps_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   cps_pkg::cps_cfg_type cfg;
   cps_pkg::cps_req_type req_ff, req_in;
   cps_pkg::cps_rsp_type rsp_ff, rsp_in;
   logic                 req_valid_ff, req_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept_in;
   logic                 proc_en;

   assign proc_en   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !proc_en;
   assign accept_in = req_valid && !req_stall;

   always_comb begin
      req_in.now_ms           = req_now_ms;
      req_in.bms_fault        = req_bms_fault;
      req_in.closing_allowed  = req_closing_allowed;
      req_in.estop_active     = req_estop_active;
      req_in.battery2_allowed = req_battery2_allowed;
      req_valid_in = accept_in || (req_valid_ff && !proc_en);
      rsp_valid_in = proc_en || (rsp_valid_ff && rsp_stall);
   end

   cps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cps_seq #(
      .FAULT_TICK_LIMIT  (FAULT_TICK_LIMIT),
      .NEG_SETTLE_MS     (NEG_SETTLE_MS),
      .PRECHARGE_DONE_MS (PRECHARGE_DONE_MS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .proc_en (proc_en),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         req_ff <= req_in;
      end
      if (proc_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_negative_duty        = rsp_ff.negative_duty;
   assign rsp_positive_duty        = rsp_ff.positive_duty;
   assign rsp_precharge_level      = rsp_ff.precharge_level;
   assign rsp_engage_status        = rsp_ff.engage_status;
   assign rsp_open_contactor_error = rsp_ff.open_contactor_error;
   assign rsp_battery2_level       = rsp_ff.battery2_level;
   assign rsp_battery2_engaged     = rsp_ff.battery2_engaged;
   assign rsp_sequence_phase       = rsp_ff.sequence_phase;

   `CPS_ASSERT_NEXT(a_proc_loads_rsp, proc_en, rsp_valid_ff, "processed item lost")
   `CPS_ASSERT_SAME(a_stall_only_full, req_stall, req_valid_ff && rsp_valid_ff && rsp_stall, "input stalled without cause")

endmodule
